// ----- hw/rtl/okus_pkg.sv -----
// ----------------------------------------------------------------------------
// okus_pkg
// Shared constants, codes and cell command type for the ordered key set.
// ----------------------------------------------------------------------------
package okus_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W  = 3;
    localparam int ST_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD           = 3'd0,
        OP_ADD_IF_ABSENT = 3'd1,
        OP_REMOVE        = 3'd2,
        OP_REMOVE_IF_PRS = 3'd3,
        OP_REMOVE_AT     = 3'd4,
        OP_INDEX_OF      = 3'd5,
        OP_READ_AT       = 3'd6,
        OP_CLEAR         = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    // command broadcast to every cell
    typedef struct packed {
        logic             append;
        logic             remove_key;
        logic             remove_pos;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] key;
    } cell_cmd_t;

endpackage

// ----- hw/rtl/okus_cell.sv -----
// ----------------------------------------------------------------------------
// okus_cell
// One table slot: holds a key, compares it and shifts in from its neighbor.
// ----------------------------------------------------------------------------
module okus_cell (
    input  logic                          clk,
    input  logic [okus_pkg::IDX_W-1:0]    slot,
    input  okus_pkg::cell_cmd_t           cmd,
    input  logic [okus_pkg::KEY_W-1:0]    right_entry,
    input  logic                          shift_in,
    output logic                          shift_out,
    output logic                          match,
    output logic [okus_pkg::KEY_W-1:0]    entry
);
    import okus_pkg::*;

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             slot_valid;
    logic             shift_here;
    logic             append_here;

    assign slot_valid  = {1'b0, slot} < cmd.count;
    assign match       = slot_valid && (entry_reg == cmd.key);
    assign shift_here  = shift_in
                         || (cmd.remove_key && match)
                         || (cmd.remove_pos && (slot == cmd.pos));
    assign shift_out   = shift_here;
    assign append_here = cmd.append && ({1'b0, slot} == cmd.count);
    assign entry       = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift_here)
        begin
            entry_next = right_entry;
        end
        else if (append_here)
        begin
            entry_next = cmd.key;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hw/rtl/ordered_unique_key_set.sv -----
// ----------------------------------------------------------------------------
// ordered_unique_key_set
// Insertion-ordered set of unique keys kept in a row of compare/shift cells.
//
//   channel  direction  handshake              fields
//   req      in         req_valid / req_stall  op, key, position
//   rsp      out        rsp_valid / rsp_stall  status, found, index,
//                                              read_value, fill_count
//
// one operation per cycle when not stalled; all cells compare in parallel
// and a removal ripples a shift flag down the cell row in the same cycle
// the result is registered and shown in the cycle after the request transfer
// req_stall is high only while a response is held by rsp_stall
// reset clears the fill count and response valid; cell contents are kept
// ----------------------------------------------------------------------------
module ordered_unique_key_set (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [okus_pkg::OP_W-1:0]     op,
    input  logic [okus_pkg::KEY_W-1:0]    key,
    input  logic [okus_pkg::IDX_W-1:0]    position,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [okus_pkg::ST_W-1:0]     status,
    output logic                          found,
    output logic [okus_pkg::IDX_W-1:0]    index,
    output logic [okus_pkg::KEY_W-1:0]    read_value,
    output logic [okus_pkg::CNT_W-1:0]    fill_count
);
    import okus_pkg::*;

    logic                 accept;
    op_t                  op_code;
    cell_cmd_t            cmd;
    logic [KEY_W-1:0]     entries  [DEPTH];
    logic [KEY_W-1:0]     rights   [DEPTH];
    logic [DEPTH:0]       shifts;
    logic [DEPTH-1:0]     cell_hits;

    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic                 pos_ok;
    logic                 full;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 rsp_valid_reg;
    logic [ST_W-1:0]      status_reg;
    logic [ST_W-1:0]      status_next;
    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     index_reg;
    logic [KEY_W-1:0]     value_reg;
    logic [KEY_W-1:0]     value_next;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign op_code   = op_t'(op);
    assign pos_ok    = {1'b0, position} < count_reg;
    assign full      = count_reg == CNT_W'(DEPTH);

    // cell row
    assign shifts[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == DEPTH - 1)
            begin : g_last
                assign rights[gi] = entries[gi];
            end
            else
            begin : g_mid
                assign rights[gi] = entries[gi+1];
            end

            okus_cell u_cell (
                .clk         (clk),
                .slot        (IDX_W'(gi)),
                .cmd         (cmd),
                .right_entry (rights[gi]),
                .shift_in    (shifts[gi]),
                .shift_out   (shifts[gi+1]),
                .match       (cell_hits[gi]),
                .entry       (entries[gi])
            );
        end
    endgenerate

    // keys are unique, so at most one match
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_idx = hit_idx | (cell_hits[i] ? IDX_W'(i) : '0);
        end
    end

    assign hit = |cell_hits;

    always_comb
    begin
        cmd.append     = 1'b0;
        cmd.remove_key = 1'b0;
        cmd.remove_pos = 1'b0;
        cmd.pos        = position;
        cmd.count      = count_reg;
        cmd.key        = key;
        count_next     = count_reg;
        status_next    = ST_OK;
        found_next     = 1'b0;
        value_next     = '0;
        unique case (op_code)
            OP_ADD, OP_ADD_IF_ABSENT:
            begin
                found_next = hit;
                if (hit)
                begin
                    status_next = (op_code == OP_ADD) ? ST_PRESENT : ST_OK;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.append = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_REMOVE, OP_REMOVE_IF_PRS:
            begin
                found_next     = hit;
                cmd.remove_key = accept;
                if (hit)
                begin
                    count_next = count_reg - 1'b1;
                end
                else if (op_code == OP_REMOVE)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_REMOVE_AT:
            begin
                if (pos_ok)
                begin
                    cmd.remove_pos = accept;
                    count_next     = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_INDEX_OF:
            begin
                found_next = hit;
                if (!hit)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_READ_AT:
            begin
                if (pos_ok)
                begin
                    value_next = entries[position];
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            found_reg  <= found_next;
            index_reg  <= found_next ? hit_idx : '0;
            value_reg  <= value_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign index      = index_reg;
    assign read_value = value_reg;
    assign fill_count = count_reg;

    // checks
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("no response after request transfer");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && found) |-> (status == ST_OK || status == ST_PRESENT))
        else $error("found key with error status");

    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_RANGE) |-> (!found && read_value == '0))
        else $error("out of range response carries data");

    a_multi_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hits))
        else $error("duplicate key in table");

endmodule
